FILE: design/rsort_pkg.sv
// Package for the record insertion sorter.
// Holds the capacity, the record and control types shared by the cell chain and the top level.
// Depends on nothing.
package rsort_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned ScoreW   = 10;
  localparam int unsigned TotalW   = 12;
  localparam int unsigned TagW     = 8;

  typedef struct packed {
    logic              vld;
    logic [TotalW-1:0] total;
    logic [TagW-1:0]   tag;
  } rsort_rec_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } rsort_ctrl_t;

endpackage

FILE: design/record_insertion_sorter.sv
// Top level of the record insertion sorter: a chain of sorting cells and its control.
// Depends on rsort_pkg and rsort_cell.
//
//   channel | valid       | stall        | fields
//   input   | in_valid_i  | in_stall_o   | math, physics, chemistry scores, tag, last_item
//   output  | out_valid_o | out_stall_i  | sorted_tag, total_score, last_result, overflow_flag
//
// Loading takes one cycle per record; every cell compares against the new total in parallel.
// The item marked last starts emission, which takes one cycle per stored record from the head
// cell while out_stall_i is low; the input is stalled until the final result beat is taken.
// Reset clears the valid bit of every cell, the overflow mark and the emission state.
// A stalled output holds the head record; the chain shifts only when a beat is taken.
module record_insertion_sorter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rsort_pkg::ScoreW-1:0] math_score_i,
  input  logic [rsort_pkg::ScoreW-1:0] physics_score_i,
  input  logic [rsort_pkg::ScoreW-1:0] chemistry_score_i,
  input  logic [rsort_pkg::TagW-1:0]   record_tag_i,
  input  logic                         last_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rsort_pkg::TagW-1:0]   sorted_tag_o,
  output logic [rsort_pkg::TotalW-1:0] total_score_o,
  output logic                         last_result_o,
  output logic                         overflow_flag_o
);
  import rsort_pkg::*;

  rsort_rec_t  rec [Capacity];
  rsort_rec_t  new_rec;
  rsort_rec_t  head_rec;
  rsort_rec_t  tail_rec;
  rsort_ctrl_t ctrl;
  logic        in_acc, out_acc, full;
  logic        emit_q, emit_d;
  logic        drop_q, drop_d;
  logic [Capacity-1:0] vld_vec;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign full = rec[Capacity-1].vld;

  assign new_rec.vld   = 1'b1;
  assign new_rec.total = TotalW'({2'b00, math_score_i}) + TotalW'({2'b00, physics_score_i})
                       + TotalW'({2'b00, chemistry_score_i});
  assign new_rec.tag   = record_tag_i;

  // The head sees a virtual record that always stays in front; the tail pulls in an empty one.
  assign head_rec.vld   = 1'b1;
  assign head_rec.total = '0;
  assign head_rec.tag   = '0;
  assign tail_rec.vld   = 1'b0;
  assign tail_rec.total = '0;
  assign tail_rec.tag   = '0;

  assign ctrl.ins   = in_acc && !full;
  assign ctrl.shift = out_acc;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    rsort_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .new_i  (new_rec),
      .prev_i ((i == 0) ? head_rec : rec[(i == 0) ? 0 : i-1]),
      .next_i ((i == Capacity-1) ? tail_rec : rec[(i == Capacity-1) ? i : i+1]),
      .rec_o  (rec[i])
    );
    assign vld_vec[i] = rec[i].vld;
  end

  always_comb begin
    emit_d = emit_q;
    drop_d = drop_q;
    if (in_acc) begin
      if (full) begin
        drop_d = 1'b1;
      end
      if (last_item_i) begin
        emit_d = 1'b1;
      end
    end
    if (out_acc && last_result_o) begin
      emit_d = 1'b0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      emit_q <= emit_d;
      drop_q <= drop_d;
    end
  end

  assign in_stall_o      = emit_q;
  assign out_valid_o     = emit_q;
  assign sorted_tag_o    = rec[0].tag;
  assign total_score_o   = rec[0].total;
  assign last_result_o   = !rec[1].vld;
  assign overflow_flag_o = drop_q;

`ifndef SYNTHESIS
  a_emit_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> rec[0].vld)
    else $error("Emission runs with an empty head cell.");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_result_o) |=> (!rec[0].vld && !drop_q))
    else $error("Chain not empty after the final result beat.");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, vld_vec} + {{Capacity{1'b0}}, 1'b1}))
    else $error("Valid cells are not contiguous from the head.");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec[1].vld |-> (rec[0].total <= rec[1].total))
    else $error("Head cells are out of order.");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!drop_q && !emit_q && $past(!emit_q) && drop_d) |-> full)
    else $error("Overflow marked while the chain has room.");
`endif

endmodule

FILE: design/rsort_cell.sv
// One cell of the insertion chain for the record insertion sorter.
// Holds one record, inserts a broadcast record in order or shifts toward the head.
// Depends on rsort_pkg.
module rsort_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsort_pkg::rsort_ctrl_t ctrl_i,
  input  rsort_pkg::rsort_rec_t  new_i,
  input  rsort_pkg::rsort_rec_t  prev_i,
  input  rsort_pkg::rsort_rec_t  next_i,
  output rsort_pkg::rsort_rec_t  rec_o
);
  import rsort_pkg::*;

  rsort_rec_t rec_q, rec_d;
  logic       own_keeps;
  logic       prev_keeps;

  // Equal totals stay in front of the new record, which keeps the sort stable.
  assign own_keeps  = rec_q.vld && (rec_q.total <= new_i.total);
  assign prev_keeps = prev_i.vld && (prev_i.total <= new_i.total);

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.ins) begin
      if (own_keeps) begin
        rec_d = rec_q;
      end else if (prev_keeps) begin
        rec_d = new_i;
      end else begin
        rec_d = prev_i;
      end
    end else if (ctrl_i.shift) begin
      rec_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule
